// ----- sv/acs_pkg.sv -----
`timescale 1ns / 1ps

package acs_pkg;

	localparam int RAW_W       = 16;
	localparam int SHIFT       = 4;
	localparam int SAMPLE_W    = RAW_W - SHIFT;
	localparam int OUT_W       = 16;
	localparam int AXES        = 3;
	localparam int MOUNTS      = 8;
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 16;

	localparam logic [CFG_INDEX_W-1:0] REG_REMAP_ENABLE   = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_MOUNT_POSITION = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_OFFSET_X       = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_OFFSET_Y       = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_OFFSET_Z       = 3'd4;

	// Source axis of each result axis for every mounting position.
	localparam logic [1:0] MOUNT_SRC [MOUNTS][AXES] = '{
		'{2'd1, 2'd0, 2'd2},
		'{2'd0, 2'd1, 2'd2},
		'{2'd1, 2'd0, 2'd2},
		'{2'd0, 2'd1, 2'd2},
		'{2'd1, 2'd0, 2'd2},
		'{2'd0, 2'd1, 2'd2},
		'{2'd1, 2'd0, 2'd2},
		'{2'd0, 2'd1, 2'd2}
	};

	// Whether the selected source axis is negated.
	localparam logic MOUNT_NEG [MOUNTS][AXES] = '{
		'{1'b0, 1'b1, 1'b0},
		'{1'b1, 1'b1, 1'b0},
		'{1'b1, 1'b0, 1'b0},
		'{1'b0, 1'b0, 1'b0},
		'{1'b1, 1'b1, 1'b1},
		'{1'b0, 1'b1, 1'b1},
		'{1'b0, 1'b0, 1'b1},
		'{1'b1, 1'b0, 1'b1}
	};

	typedef struct packed {
		logic load1;
		logic accept;
		logic vib;
		logic start;
		logic adv2;
	} acs_ctrl_t;

	typedef struct packed {
		logic                          remap_en;
		logic [2:0]                    mount;
		logic [AXES-1:0][OUT_W-1:0]    offset;
	} acs_cfg_t;

	typedef logic [AXES-1:0][SAMPLE_W-1:0] acs_vals_t;

endpackage

// ----- sv/accel_sample_conditioner_top.sv -----
`timescale 1ns / 1ps

// Accelerometer sample conditioner. Each request on the slave stream carries
// the three raw axis words and, in tuser, the vibration flag; each produces
// exactly one conditioned result on the master stream. One request is taken
// every clock cycle unless the master stream stalls: per-axis running sums
// turn the history mean into a single add and subtract per sample, the
// division by the history depth is a reciprocal multiply in the second stage,
// and the remap and offset subtraction fill the third. Configuration writes
// are accepted on every cycle but should only be made while the block is idle.

module accel_sample_conditioner_top #(
	parameter int HISTORY_DEPTH = 12
) (
	input  logic                                         clk,
	input  logic                                         arst_n,
	input  logic                                         s_axis_tvalid,
	output logic                                         s_axis_tready,
	// raw_x [15:0], raw_y [31:16], raw_z [47:32]
	input  logic [acs_pkg::AXES*acs_pkg::RAW_W-1:0]      s_axis_tdata,
	// vibrating [0]
	input  logic                                         s_axis_tuser,
	output logic                                         m_axis_tvalid,
	input  logic                                         m_axis_tready,
	// accel_x [15:0], accel_y [31:16], accel_z [47:32]
	output logic [acs_pkg::AXES*acs_pkg::OUT_W-1:0]      m_axis_tdata,
	input  logic                                         cfg_valid,
	output logic                                         cfg_ready,
	input  logic [acs_pkg::CFG_INDEX_W-1:0]              cfg_index,
	input  logic [acs_pkg::CFG_DATA_W-1:0]               cfg_data
);
	import acs_pkg::*;

	localparam int SlotW = $clog2(HISTORY_DEPTH);

	logic [SlotW-1:0] slot_q;
	logic             in_ep_q;
	logic             v1_s1;
	logic             v2_s2;
	logic             en1;
	logic             en2;
	logic             en3;
	logic             accept;
	acs_ctrl_t        ctrl;
	acs_cfg_t         cfg_q;
	acs_vals_t        vals;

	assign en3           = !m_axis_tvalid || m_axis_tready;
	assign en2           = !v2_s2 || en3;
	assign en1           = !v1_s1 || en2;
	assign s_axis_tready = en1;
	assign accept        = s_axis_tvalid && en1;
	assign cfg_ready     = 1'b1;

	always_comb begin
		ctrl.load1  = en1;
		ctrl.accept = accept;
		ctrl.vib    = s_axis_tuser;
		ctrl.start  = s_axis_tuser && !in_ep_q;
		ctrl.adv2   = en2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1         <= 1'b0;
			v2_s2         <= 1'b0;
			m_axis_tvalid <= 1'b0;
		end else begin
			if (en1) begin
				v1_s1 <= s_axis_tvalid;
			end
			if (en2) begin
				v2_s2 <= v1_s1;
			end
			if (en3) begin
				m_axis_tvalid <= v2_s2;
			end
		end
	end

	// The first vibrating sample of an episode lands in slot zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q  <= '0;
			in_ep_q <= 1'b0;
		end else if (accept) begin
			if (s_axis_tuser) begin
				in_ep_q <= 1'b1;
				if (ctrl.start) begin
					slot_q <= SlotW'(1);
				end else if (int'(slot_q) == HISTORY_DEPTH - 1) begin
					slot_q <= '0;
				end else begin
					slot_q <= slot_q + SlotW'(1);
				end
			end else begin
				in_ep_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_REMAP_ENABLE:   cfg_q.remap_en  <= cfg_data[0];
				REG_MOUNT_POSITION: cfg_q.mount     <= cfg_data[2:0];
				REG_OFFSET_X:       cfg_q.offset[0] <= cfg_data;
				REG_OFFSET_Y:       cfg_q.offset[1] <= cfg_data;
				REG_OFFSET_Z:       cfg_q.offset[2] <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	for (genvar a = 0; a < AXES; a++) begin : g_lane
		acs_lane #(
			.HISTORY_DEPTH(HISTORY_DEPTH)
		) u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.ctrl   (ctrl),
			.slot   (slot_q),
			.raw    (s_axis_tdata[a*RAW_W +: RAW_W]),
			.value  (vals[a])
		);
	end

	acs_merge u_merge (
		.clk    (clk),
		.adv    (en3),
		.cfg    (cfg_q),
		.vals   (vals),
		.result (m_axis_tdata)
	);

	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		int'(slot_q) < HISTORY_DEPTH)
		else $error("history slot out of range");

	a_episode_start: assert property (@(posedge clk) disable iff (!arst_n)
		accept && s_axis_tuser && !in_ep_q |=> in_ep_q && slot_q == SlotW'(1))
		else $error("episode start did not restart the history");

	a_episode_end: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !s_axis_tuser |=> !in_ep_q)
		else $error("quiet sample left the episode open");

	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		v2_s2 && !en2 |=> v2_s2)
		else $error("stalled middle stage lost its request");

endmodule

// ----- sv/acs_lane.sv -----
`timescale 1ns / 1ps

module acs_lane #(
	parameter int HISTORY_DEPTH = 12,
	localparam int SlotW = $clog2(HISTORY_DEPTH)
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  acs_pkg::acs_ctrl_t                ctrl,
	input  logic [SlotW-1:0]                  slot,
	input  logic [acs_pkg::RAW_W-1:0]         raw,
	output logic [acs_pkg::SAMPLE_W-1:0]      value
);
	import acs_pkg::*;

	localparam int SumW = $clog2(HISTORY_DEPTH * (1 << (SAMPLE_W - 1))) + 1;
	localparam int DivL = $clog2(HISTORY_DEPTH);
	localparam int DivK = SumW + DivL;
	localparam int MulW = SumW + 1;
	localparam longint DivM = ((longint'(1) << DivK) + HISTORY_DEPTH - 1) / HISTORY_DEPTH;
	localparam logic [MulW-1:0] DivMul = MulW'(DivM);
	localparam logic signed [SumW-1:0] DepthLess1 = SumW'(HISTORY_DEPTH - 1);

	logic [SAMPLE_W-1:0] hist_q [HISTORY_DEPTH];
	logic [SAMPLE_W-1:0] lq_q;
	logic signed [SumW-1:0] sum_q;

	logic signed [SumW-1:0] sample_ext;
	logic signed [SumW-1:0] lq_ext;
	logic signed [SumW-1:0] old_ext;
	logic signed [2*SumW-1:0] fill_full;
	logic signed [SumW-1:0] sum_next;

	logic                   vib_s1;
	logic signed [SumW-1:0] sum_s1;
	logic                   vib_s2;
	logic                   neg_s2;
	logic [SumW+MulW-1:0]   prod_s2;
	logic [SAMPLE_W-1:0]    samp_s2;

	logic [SumW-1:0]        mag;
	logic [SAMPLE_W-1:0]    quo;

	always_comb begin
		sample_ext = {{(SumW - SAMPLE_W){raw[RAW_W-1]}}, raw[RAW_W-1:SHIFT]};
		lq_ext     = {{(SumW - SAMPLE_W){lq_q[SAMPLE_W-1]}}, lq_q};
		old_ext    = {{(SumW - SAMPLE_W){hist_q[slot][SAMPLE_W-1]}}, hist_q[slot]};
		fill_full  = lq_ext * DepthLess1;
		if (ctrl.start) begin
			sum_next = fill_full[SumW-1:0] + sample_ext;
		end else begin
			sum_next = sum_q - old_ext + sample_ext;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lq_q  <= '0;
			sum_q <= '0;
			for (int k = 0; k < HISTORY_DEPTH; k++) begin
				hist_q[k] <= '0;
			end
		end else if (ctrl.accept) begin
			if (ctrl.vib) begin
				sum_q <= sum_next;
				for (int k = 0; k < HISTORY_DEPTH; k++) begin
					if (ctrl.start) begin
						hist_q[k] <= (k == 0) ? raw[RAW_W-1:SHIFT] : lq_q;
					end else if (slot == SlotW'(k)) begin
						hist_q[k] <= raw[RAW_W-1:SHIFT];
					end
				end
			end else begin
				lq_q <= raw[RAW_W-1:SHIFT];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load1) begin
			vib_s1 <= ctrl.vib;
			sum_s1 <= ctrl.vib ? sum_next : sample_ext;
		end
	end

	assign mag = sum_s1[SumW-1] ? SumW'(-sum_s1) : SumW'(sum_s1);

	always_ff @(posedge clk) begin
		if (ctrl.adv2) begin
			vib_s2  <= vib_s1;
			neg_s2  <= sum_s1[SumW-1];
			prod_s2 <= mag * DivMul;
			samp_s2 <= sum_s1[SAMPLE_W-1:0];
		end
	end

	always_comb begin
		quo = prod_s2[DivK +: SAMPLE_W];
		if (!vib_s2) begin
			value = samp_s2;
		end else if (neg_s2) begin
			value = -quo;
		end else begin
			value = quo;
		end
	end

endmodule

// ----- sv/acs_merge.sv -----
`timescale 1ns / 1ps

module acs_merge (
	input  logic                                    clk,
	input  logic                                    adv,
	input  acs_pkg::acs_cfg_t                       cfg,
	input  acs_pkg::acs_vals_t                      vals,
	output logic [acs_pkg::AXES*acs_pkg::OUT_W-1:0] result
);
	import acs_pkg::*;

	logic [AXES-1:0][OUT_W-1:0] res;

	always_comb begin
		logic [1:0]       src;
		logic             neg;
		logic [OUT_W-1:0] v16;
		for (int a = 0; a < AXES; a++) begin
			src = cfg.remap_en ? MOUNT_SRC[cfg.mount][a] : 2'(a);
			neg = cfg.remap_en & MOUNT_NEG[cfg.mount][a];
			v16 = {{(OUT_W - SAMPLE_W){vals[src][SAMPLE_W-1]}}, vals[src]};
			if (neg) begin
				v16 = -v16;
			end
			res[a] = v16 - cfg.offset[a];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			result <= res;
		end
	end

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps

module tb;
	import acs_pkg::*;

	localparam int DEPTH      = 12;
	localparam int CYCLE_CAP  = 600000;
	localparam int PHASES     = 12;
	localparam int PHASE_SIZE = 161;
	localparam int ROWS       = 24;

	// Sign and permutation matrix of every mounting position, row per result axis.
	localparam int AXIS_MATRIX [8][3][3] = '{
		'{'{ 0,  1,  0}, '{-1,  0,  0}, '{ 0,  0,  1}},
		'{'{-1,  0,  0}, '{ 0, -1,  0}, '{ 0,  0,  1}},
		'{'{ 0, -1,  0}, '{ 1,  0,  0}, '{ 0,  0,  1}},
		'{'{ 1,  0,  0}, '{ 0,  1,  0}, '{ 0,  0,  1}},
		'{'{ 0, -1,  0}, '{-1,  0,  0}, '{ 0,  0, -1}},
		'{'{ 1,  0,  0}, '{ 0, -1,  0}, '{ 0,  0, -1}},
		'{'{ 0,  1,  0}, '{ 1,  0,  0}, '{ 0,  0, -1}},
		'{'{-1,  0,  0}, '{ 0,  1,  0}, '{ 0,  0, -1}}
	};

	typedef logic [2:0][15:0] accel_t;

	typedef struct packed {
		logic [15:0] rx;
		logic [15:0] ry;
		logic [15:0] rz;
		logic        vib;
		logic        known;
		accel_t      want;
	} row_t;

	// Rows with known set carry a result that follows directly from the reset configuration.
	localparam row_t DIRECTED [ROWS] = '{
		'{16'h7FF0, 16'h8000, 16'h0010, 1'b1, 1'b0, 48'h0},
		'{16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b1, {16'h0000, 16'h0000, 16'h0000}},
		'{16'h7FF0, 16'h7FFF, 16'h000F, 1'b0, 1'b1, {16'h0000, 16'h07FF, 16'h07FF}},
		'{16'h8000, 16'h800F, 16'hFFFF, 1'b0, 1'b1, {16'hFFFF, 16'hF800, 16'hF800}},
		'{16'h1234, 16'hABCD, 16'h5A5A, 1'b0, 1'b1, {16'h05A5, 16'hFABC, 16'h0123}},
		'{16'h8000, 16'h8000, 16'h8000, 1'b0, 1'b1, {16'hF800, 16'hF800, 16'hF800}},
		'{16'h7FF0, 16'h8000, 16'hFFF0, 1'b1, 1'b0, 48'h0},
		'{16'h7FF0, 16'h7FF0, 16'h0010, 1'b1, 1'b0, 48'h0},
		'{16'h7FF0, 16'h8000, 16'hFFF0, 1'b1, 1'b0, 48'h0},
		'{16'h0010, 16'h7FF0, 16'h0010, 1'b1, 1'b0, 48'h0},
		'{16'h7FF0, 16'h8000, 16'hFFF0, 1'b1, 1'b0, 48'h0},
		'{16'h7FF0, 16'h7FF0, 16'h8000, 1'b1, 1'b0, 48'h0},
		'{16'hFFF0, 16'h8000, 16'h7FF0, 1'b1, 1'b0, 48'h0},
		'{16'h7FF0, 16'h0010, 16'h8000, 1'b1, 1'b0, 48'h0},
		'{16'h7FF0, 16'h8000, 16'hFFF0, 1'b1, 1'b0, 48'h0},
		'{16'h8000, 16'h7FF0, 16'h7FF0, 1'b1, 1'b0, 48'h0},
		'{16'h7FF0, 16'h8000, 16'h0000, 1'b1, 1'b0, 48'h0},
		'{16'hFFF0, 16'hFFF0, 16'h8000, 1'b1, 1'b0, 48'h0},
		'{16'h7FF0, 16'h8000, 16'h7FF0, 1'b1, 1'b0, 48'h0},
		'{16'h8000, 16'h7FF0, 16'hFFF0, 1'b1, 1'b0, 48'h0},
		'{16'h7FF0, 16'h7FF0, 16'h7FF0, 1'b0, 1'b1, {16'h07FF, 16'h07FF, 16'h07FF}},
		'{16'h0010, 16'hFFF0, 16'h7FF0, 1'b1, 1'b0, 48'h0},
		'{16'h0010, 16'hFFF0, 16'h7FF0, 1'b1, 1'b0, 48'h0},
		'{16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 1'b1, {16'hFFFF, 16'hFFFF, 16'hFFFF}}
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [47:0] s_axis_tdata = '0;
	logic        s_axis_tuser = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [47:0] m_axis_tdata;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;

	accel_sample_conditioner_top #(
		.HISTORY_DEPTH(DEPTH)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// Predictor state and configuration copy.
	int       hist [DEPTH][3];
	int       quiet_val [3];
	int       slot;
	bit       in_episode;
	bit       remap_on;
	bit [2:0] mount_sel;
	int       offs [3];

	accel_t   pending [$];
	bit       cur_known;
	accel_t   cur_want;
	int       sender_idle;
	int       receiver_stall;
	int       cycles;
	int       errors;
	int       samples_sent;
	int       vib_sent;
	int       results_checked;
	accel_t   got;
	accel_t   exp_res;
	string    axis_name [3] = '{"accel_x", "accel_y", "accel_z"};

	function automatic accel_t condition_sample(logic [15:0] rx, logic [15:0] ry,
			logic [15:0] rz, logic vib);
		int     s [3];
		int     r [3];
		int     sum;
		accel_t res;
		s[0] = $signed(rx[15:4]);
		s[1] = $signed(ry[15:4]);
		s[2] = $signed(rz[15:4]);
		if (vib) begin
			if (!in_episode) begin
				for (int i = 0; i < DEPTH; i++)
					for (int a = 0; a < 3; a++)
						hist[i][a] = quiet_val[a];
				slot = 0;
				in_episode = 1'b1;
			end
			for (int a = 0; a < 3; a++)
				hist[slot][a] = s[a];
			slot = (slot + 1) % DEPTH;
			for (int a = 0; a < 3; a++) begin
				sum = 0;
				for (int i = 0; i < DEPTH; i++)
					sum += hist[i][a];
				s[a] = sum / DEPTH;
			end
		end else begin
			in_episode = 1'b0;
			quiet_val = s;
		end
		for (int a = 0; a < 3; a++) begin
			if (remap_on) begin
				r[a] = 0;
				for (int i = 0; i < 3; i++)
					r[a] += AXIS_MATRIX[mount_sel][a][i] * s[i];
			end else begin
				r[a] = s[a];
			end
			res[a] = 16'(r[a] - offs[a]);
		end
		return res;
	endfunction

	function automatic logic [15:0] pick_raw();
		int v;
		v = $urandom_range(0, 64);
		case ($urandom_range(0, 4))
			0: return {12'h7FF, 4'($urandom)};
			1: return {12'h800, 4'($urandom)};
			2: return 16'((v - 32) * 16 + $urandom_range(0, 15));
			default: return 16'($urandom);
		endcase
	endfunction

	always @(negedge clk)
		m_axis_tready <= ($urandom_range(0, 99) >= receiver_stall);

	always @(posedge clk) begin
		if (arst_n) begin
			cycles++;
			if (cycles > CYCLE_CAP) begin
				$display("tb: failure");
				$finish;
			end else begin
				if (s_axis_tvalid && s_axis_tready) begin
					exp_res = condition_sample(s_axis_tdata[15:0], s_axis_tdata[31:16],
						s_axis_tdata[47:32], s_axis_tuser);
					pending.push_back(cur_known ? cur_want : exp_res);
					samples_sent++;
					if (s_axis_tuser)
						vib_sent++;
				end
				if (m_axis_tvalid && m_axis_tready) begin
					got = m_axis_tdata;
					if (pending.size() == 0) begin
						$error("result %h arrived with no request outstanding", got);
						errors++;
					end else begin
						exp_res = pending.pop_front();
						results_checked++;
						for (int a = 0; a < 3; a++)
							if (got[a] !== exp_res[a]) begin
								$error("%s expected %h actual %h", axis_name[a], exp_res[a],
									got[a]);
								errors++;
							end
					end
				end
			end
		end
	end

	task automatic send_sample(logic [15:0] rx, logic [15:0] ry, logic [15:0] rz, logic vib,
			logic known, accel_t want);
		int gap;
		gap = 0;
		while ($urandom_range(0, 99) < sender_idle)
			gap++;
		if (gap > 0) begin
			s_axis_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tdata = {rz, ry, rx};
		s_axis_tuser = vib;
		cur_known = known;
		cur_want = want;
		s_axis_tvalid = 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		@(negedge clk);
	endtask

	task automatic drain();
		s_axis_tvalid = 1'b0;
		while (pending.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [15:0] val);
		cfg_index = idx;
		cfg_data = val;
		cfg_valid = 1'b1;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_REMAP_ENABLE:   remap_on = val[0];
			REG_MOUNT_POSITION: mount_sel = val[2:0];
			REG_OFFSET_X:       offs[0] = int'($signed(val));
			REG_OFFSET_Y:       offs[1] = int'($signed(val));
			REG_OFFSET_Z:       offs[2] = int'($signed(val));
			default: ;
		endcase
		@(negedge clk);
	endtask

	initial begin
		logic [15:0] off;
		bit          vib_state;
		bit          noisy;
		int          run_left;
		logic        vib;
		vib_state = 1'b0;
		noisy = 1'b0;
		run_left = 0;
		sender_idle = 11;
		receiver_stall = 67;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (int k = 0; k < ROWS; k++)
			send_sample(DIRECTED[k].rx, DIRECTED[k].ry, DIRECTED[k].rz, DIRECTED[k].vib,
				DIRECTED[k].known, DIRECTED[k].want);

		for (int p = 0; p < PHASES; p++) begin
			drain();
			if (p == 4) begin
				sender_idle = 67;
				receiver_stall = 11;
			end else if (p == 8) begin
				sender_idle = 0;
				receiver_stall = 0;
			end
			write_reg(REG_REMAP_ENABLE, (p < 8) ? 16'd1 : 16'(p % 2));
			write_reg(REG_MOUNT_POSITION, (p < 8) ? 16'(p) : 16'($urandom_range(0, 7)));
			for (int a = 0; a < 3; a++) begin
				case (p)
					1: off = 16'h8000;
					2: off = 16'h7FFF;
					3: off = 16'h0000;
					default: off = 16'($urandom);
				endcase
				write_reg(REG_OFFSET_X + 3'(a), off);
			end
			cfg_valid = 1'b0;

			for (int k = 0; k < PHASE_SIZE; k++) begin
				if ($urandom_range(0, 299) == 0)
					drain();
				// Mostly whole vibration episodes and quiet runs; now and then a noisy run.
				if (run_left == 0) begin
					vib_state = !vib_state;
					run_left = vib_state ? $urandom_range(1, 30) : $urandom_range(1, 6);
					noisy = ($urandom_range(0, 9) == 0);
				end
				run_left--;
				vib = noisy ? 1'($urandom_range(0, 1)) : vib_state;
				send_sample(pick_raw(), pick_raw(), pick_raw(), vib, 1'b0, '0);
			end
		end

		drain();
		repeat (10) @(negedge clk);
		if (pending.size() != 0) begin
			$error("%0d results never arrived", pending.size());
			errors++;
		end
		$display("Sent %0d samples (%0d vibrating) over %0d configuration phases.",
			samples_sent, vib_sent, PHASES);
		$display("Checked %0d results across all mounting positions and offset extremes.",
			results_checked);
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
